// File: rtl/tcd_pkg.sv
// Shared types and constants for the Telnet command deframer.
package tcd_pkg;

   // Telnet command codes that the grammar looks at.
   localparam logic [7:0] CODE_SE   = 8'd240;
   localparam logic [7:0] CODE_SB   = 8'd250;
   localparam logic [7:0] CODE_WILL = 8'd251;
   localparam logic [7:0] CODE_DONT = 8'd254;
   localparam logic [7:0] CODE_IAC  = 8'd255;

   // Role of one byte in the IAC command grammar.
   typedef enum logic [3:0] {
      KIND_DATA    = 4'd0,
      KIND_LEAD    = 4'd1,
      KIND_LITERAL = 4'd2,
      KIND_COMMAND = 4'd3,
      KIND_NEGOT   = 4'd4,
      KIND_OPTION  = 4'd5,
      KIND_SB      = 4'd6,
      KIND_SB_BYTE = 4'd7,
      KIND_SB_IAC  = 4'd8,
      KIND_SE      = 4'd9
   } kind_type;

   // Parser mode, one-hot.
   typedef enum logic [4:0] {
      MODE_IDLE   = 5'b00001,
      MODE_IAC    = 5'b00010,
      MODE_OPTION = 5'b00100,
      MODE_SB     = 5'b01000,
      MODE_SB_IAC = 5'b10000
   } mode_type;

   // One input word as held in the input register.
   typedef struct packed {
      logic       packet_end;
      logic [7:0] byte_value;
   } in_word_type;

   // One classified result word.
   typedef struct packed {
      logic       unfinished;
      logic [7:0] byte_out;
      kind_type   byte_kind;
   } rsp_word_type;

endpackage

// File: rtl/tcd_in_stage.sv
// Input register stage of the Telnet command deframer.
module tcd_in_stage
   import tcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        advance,
   output logic        in_valid,
   output in_word_type in_word
);

   logic        valid_ff;
   logic        valid_in;
   in_word_type word_ff;
   logic        load;

   // The stage takes a new word when it is empty or its word moves on.
   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.byte_value <= req_tdata;
         word_ff.packet_end <= req_tlast;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

// File: rtl/tcd_classifier.sv
// Parser mode register and byte classification logic.
module tcd_classifier
   import tcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  in_word_type  in_word,
   output rsp_word_type result
);

   mode_type mode_ff;
   mode_type mode_in;
   mode_type next_mode;
   kind_type kind;
   logic [7:0] b;

   assign b = in_word.byte_value;

   // Classify the byte and pick the mode that follows it.
   always_comb begin
      kind      = KIND_DATA;
      next_mode = MODE_IDLE;
      unique case (mode_ff)
         MODE_IAC: begin
            if (b == CODE_IAC || b < CODE_SE) begin
               kind      = KIND_LITERAL;
               next_mode = MODE_IDLE;
            end else if (b >= CODE_WILL && b <= CODE_DONT) begin
               kind      = KIND_NEGOT;
               next_mode = MODE_OPTION;
            end else if (b == CODE_SB) begin
               kind      = KIND_SB;
               next_mode = MODE_SB;
            end else begin
               kind      = KIND_COMMAND;
               next_mode = MODE_IDLE;
            end
         end
         MODE_OPTION: begin
            kind      = KIND_OPTION;
            next_mode = MODE_IDLE;
         end
         MODE_SB: begin
            if (b == CODE_IAC) begin
               kind      = KIND_SB_IAC;
               next_mode = MODE_SB_IAC;
            end else begin
               kind      = KIND_SB_BYTE;
               next_mode = MODE_SB;
            end
         end
         MODE_SB_IAC: begin
            if (b == CODE_SE) begin
               kind      = KIND_SE;
               next_mode = MODE_IDLE;
            end else if (b == CODE_IAC) begin
               kind      = KIND_SB_IAC;
               next_mode = MODE_SB_IAC;
            end else begin
               kind      = KIND_SB_BYTE;
               next_mode = MODE_SB;
            end
         end
         default: begin
            if (b == CODE_IAC) begin
               kind      = KIND_LEAD;
               next_mode = MODE_IAC;
            end else begin
               kind      = KIND_DATA;
               next_mode = MODE_IDLE;
            end
         end
      endcase
   end

   // A packet end always sends the parser back to idle.
   always_comb begin
      mode_in = mode_ff;
      if (advance) begin
         mode_in = in_word.packet_end ? MODE_IDLE : next_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign result.byte_kind  = kind;
   assign result.byte_out   = b;
   assign result.unfinished = in_word.packet_end && (next_mode != MODE_IDLE);

`ifndef NO_ASSERTIONS
   // Nothing of a packet's parse state survives into the next packet.
   assert property (@(posedge clock) disable iff (reset)
      advance && in_word.packet_end |=> mode_ff == MODE_IDLE)
      else $error("parser mode not idle after packet end");

   // Unfinished is only flagged on a packet end that leaves a command open.
   assert property (@(posedge clock) disable iff (reset)
      result.unfinished |-> in_word.packet_end && next_mode != MODE_IDLE)
      else $error("unfinished flagged without open command at packet end");

   // SE closes a subnegotiation only right after its IAC.
   assert property (@(posedge clock) disable iff (reset)
      kind == KIND_SE |-> mode_ff == MODE_SB_IAC && b == CODE_SE)
      else $error("SE reported outside a subnegotiation IAC");
`endif

endmodule

// File: rtl/tcd_out_stage.sv
// Result register stage of the Telnet command deframer.
module tcd_out_stage
   import tcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_word_type result,
   output logic         out_free,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic [4:0]   rsp_tuser
);

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // The register can take a word when empty or when its word is taken now.
   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = word_ff.byte_out;
   assign rsp_tuser  = {word_ff.unfinished, word_ff.byte_kind};

endmodule

// File: rtl/telnet_command_deframer.sv
// Top level of the Telnet command deframer.
// Classifies a Telnet payload stream one byte per word and returns one result word per input
// word, in order. The block sustains one word per clock cycle while the output is not stalled;
// a word passes through an input register and then a result register before its result
// appears on the result port. The only parse state is the small parser mode register,
// which is read and updated as a word moves from the input register to the result register; a
// packet end (req_tlast) returns it to idle. req_tready depends combinationally on rsp_tready.
module telnet_command_deframer
   import tcd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] byte_value
   input  logic       req_tlast,   // packet_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] byte_out
   output logic [4:0] rsp_tuser    // [3:0] byte_kind, [4] unfinished
);

   logic         in_valid;
   in_word_type  in_word;
   rsp_word_type result;
   logic         out_free;
   logic         advance;

   // A word moves from the input register to the result register.
   assign advance = in_valid && out_free;

   tcd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_word    (in_word)
   );

   tcd_classifier u_classifier (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_word (in_word),
      .result  (result)
   );

   tcd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
